>>> design/ptl_pkg.sv
package ptl_pkg;

  localparam int MAX_NEST_DEF = 255;

  // Event kinds carried by a result word.
  localparam logic EV_BYTE = 1'b0;
  localparam logic EV_END  = 1'b1;

  // Token types reported on a token end.
  localparam logic [3:0] TT_ERROR      = 4'd0;
  localparam logic [3:0] TT_NUMBER     = 4'd1;
  localparam logic [3:0] TT_NAME       = 4'd2;
  localparam logic [3:0] TT_STRING     = 4'd3;
  localparam logic [3:0] TT_HEX        = 4'd4;
  localparam logic [3:0] TT_ARR_BEGIN  = 4'd5;
  localparam logic [3:0] TT_ARR_END    = 4'd6;
  localparam logic [3:0] TT_DICT_BEGIN = 4'd7;
  localparam logic [3:0] TT_DICT_END   = 4'd8;
  localparam logic [3:0] TT_NULL       = 4'd9;
  localparam logic [3:0] TT_TRUE       = 4'd10;
  localparam logic [3:0] TT_FALSE      = 4'd11;
  localparam logic [3:0] TT_OPERATOR   = 4'd12;

  // Lexer state apart from the string nesting depth, whose width is a parameter.
  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] oct_val;
    logic [1:0] oct_cnt;
    logic [1:0] wclass;
    logic [5:0] kw;      // {byte count saturating at 7, null/true/false still matching}
  } lex_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [3:0] ttype;
    logic       last;
  } res_t;

endpackage

>>> design/ptl_if.sv
interface ptl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface ptl_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] content_byte;
  logic [3:0] token_type;
  logic       run_last;

  modport source (output valid, output event_kind, output content_byte,
                  output token_type, output run_last, input ready);
  modport sink   (input valid, input event_kind, input content_byte,
                  input token_type, input run_last, output ready);
endinterface

>>> design/pdf_token_lexer_top.sv
// Channel   Dir  Payload (bits)                                              Handshake
// in_ch     in   in_byte[8], end_of_stream[1]                                valid/ready
// out_ch    out  event_kind[1], content_byte[8], token_type[4], run_last[1]  valid/ready
//
// One byte is taken per cycle while the output keeps up; its results pass through the
// input register and then the output register. The output register holds the up to
// two results of one byte and sends one word per cycle while out_ch.ready is high, so
// a byte that yields two results holds the input until its second word leaves.
// Output stalls propagate back through the input register to in_ch.ready.
// rst_n is synchronous and active low; it returns the lexer to idle between tokens.
module pdf_token_lexer_top #(
  parameter int MAX_NEST = ptl_pkg::MAX_NEST_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ptl_in_if.sink    in_ch,
  ptl_out_if.source out_ch
);

  localparam int DW = $clog2(MAX_NEST + 1);

  logic                ivld_r;
  logic [7:0]          ibyte_r;
  logic                ieos_r;
  ptl_pkg::lex_state_t st_r;
  ptl_pkg::lex_state_t st_nxt;
  logic [DW-1:0]       depth_r;
  logic [DW-1:0]       depth_nxt;
  ptl_pkg::res_t       ores_r [2];
  ptl_pkg::res_t       res0_nxt;
  ptl_pkg::res_t       res1_nxt;
  ptl_pkg::res_t       head;
  logic [1:0]          n_nxt;
  logic [1:0]          ocnt_r;
  logic                osel_r;
  logic                out_pop;
  logic                out_free;
  logic                step_go;

  ptl_step #(.MAX_NEST(MAX_NEST)) u_step (
    .c         (ibyte_r),
    .eos       (ieos_r),
    .st        (st_r),
    .depth     (depth_r),
    .st_nxt    (st_nxt),
    .depth_nxt (depth_nxt),
    .res0      (res0_nxt),
    .res1      (res1_nxt),
    .n_res     (n_nxt)
  );

  assign head     = osel_r ? ores_r[1] : ores_r[0];
  assign out_pop  = (ocnt_r != 2'd0) && out_ch.ready;
  // The output register can take a new byte's results once its last word leaves.
  assign out_free = (ocnt_r == 2'd0) || (out_pop && ocnt_r == 2'd1);
  assign step_go  = ivld_r && out_free;
  assign in_ch.ready = !ivld_r || step_go;

  assign out_ch.valid        = (ocnt_r != 2'd0);
  assign out_ch.event_kind   = head.kind;
  assign out_ch.content_byte = head.data;
  assign out_ch.token_type   = head.ttype;
  assign out_ch.run_last     = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r  <= 1'b0;
      st_r    <= '0;
      depth_r <= '0;
      ocnt_r  <= 2'd0;
      osel_r  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        ivld_r <= in_ch.valid;
      end
      if (step_go) begin
        st_r    <= st_nxt;
        depth_r <= depth_nxt;
        ocnt_r  <= n_nxt;
        osel_r  <= 1'b0;
      end else if (out_pop) begin
        ocnt_r <= ocnt_r - 2'd1;
        osel_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ibyte_r <= in_ch.in_byte;
      ieos_r  <= in_ch.end_of_stream;
    end
    if (step_go) begin
      ores_r[0] <= res0_nxt;
      ores_r[1] <= res1_nxt;
    end
  end

endmodule

>>> design/ptl_step.sv
module ptl_step #(
  parameter int MAX_NEST = ptl_pkg::MAX_NEST_DEF,
  localparam int DW = $clog2(MAX_NEST + 1)
) (
  input  logic [7:0]          c,
  input  logic                eos,
  input  ptl_pkg::lex_state_t st,
  input  logic [DW-1:0]       depth,
  output ptl_pkg::lex_state_t st_nxt,
  output logic [DW-1:0]       depth_nxt,
  output ptl_pkg::res_t       res0,
  output ptl_pkg::res_t       res1,
  output logic [1:0]          n_res
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_WORD    = 4'd2;
  localparam logic [3:0] M_STRING  = 4'd3;
  localparam logic [3:0] M_ESCAPE  = 4'd4;
  localparam logic [3:0] M_OCTAL   = 4'd5;
  localparam logic [3:0] M_LT      = 4'd6;
  localparam logic [3:0] M_HEX     = 4'd7;
  localparam logic [3:0] M_GT      = 4'd8;

  localparam logic [1:0] WC_NUMBER = 2'd0;
  localparam logic [1:0] WC_NAME   = 2'd1;
  localparam logic [1:0] WC_OTHER  = 2'd2;

  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NEST);

  typedef struct packed {
    logic [3:0]    mode;
    logic [1:0]    wclass;
    logic [5:0]    kw;
    logic          emit;
    ptl_pkg::res_t res;
  } start_t;

  typedef struct packed {
    logic [3:0]    mode;
    logic [DW-1:0] depth;
    logic          emit;
    ptl_pkg::res_t res;
  } sbyte_t;

  function automatic ptl_pkg::res_t mk_byte(logic [7:0] b);
    ptl_pkg::res_t r;
    r.kind  = ptl_pkg::EV_BYTE;
    r.data  = b;
    r.ttype = ptl_pkg::TT_ERROR;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic ptl_pkg::res_t mk_end(logic [3:0] t);
    ptl_pkg::res_t r;
    r.kind  = ptl_pkg::EV_END;
    r.data  = 8'd0;
    r.ttype = t;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return b inside {8'h00, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20};
  endfunction

  function automatic logic is_delim(logic [7:0] b);
    return b inside {"%", "(", ")", "/", "<", ">", "[", "]", "{", "}"};
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    case (k)
      2'd0: begin
        case (pos)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'd0;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'd0;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'd0;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [5:0] kw_upd(logic [5:0] kw, logic [7:0] b);
    logic [2:0] cnt;
    logic [2:0] alive;
    logic [2:0] len;
    cnt   = kw[5:3];
    alive = kw[2:0];
    for (logic [1:0] k = 2'd0; k < 2'd3; k++) begin
      len = (k == 2'd2) ? 3'd5 : 3'd4;
      if (alive[k] && (cnt >= len || kw_char(k, cnt) != b)) begin
        alive[k] = 1'b0;
      end
    end
    if (cnt != 3'd7) begin
      cnt = cnt + 3'd1;
    end
    return {cnt, alive};
  endfunction

  function automatic logic [3:0] word_type(logic [1:0] wclass, logic [5:0] kw);
    logic [3:0] t;
    if (wclass == WC_NUMBER) begin
      t = ptl_pkg::TT_NUMBER;
    end else if (wclass == WC_NAME) begin
      t = ptl_pkg::TT_NAME;
    end else if (kw[0] && kw[5:3] == 3'd4) begin
      t = ptl_pkg::TT_NULL;
    end else if (kw[1] && kw[5:3] == 3'd4) begin
      t = ptl_pkg::TT_TRUE;
    end else if (kw[2] && kw[5:3] == 3'd5) begin
      t = ptl_pkg::TT_FALSE;
    end else begin
      t = ptl_pkg::TT_OPERATOR;
    end
    return t;
  endfunction

  function automatic start_t start_tok(logic [7:0] b);
    start_t s;
    s.mode   = M_IDLE;
    s.wclass = WC_NUMBER;
    s.kw     = 6'd0;
    s.emit   = 1'b0;
    s.res    = mk_byte(b);
    if (is_space(b)) begin
      s.mode = M_IDLE;
    end else if (b == "%") begin
      s.mode = M_COMMENT;
    end else if (b == "(") begin
      s.mode = M_STRING;
    end else if (b == "<") begin
      s.mode = M_LT;
    end else if (b == ">") begin
      s.mode = M_GT;
    end else if (b == "[") begin
      s.emit = 1'b1;
      s.res  = mk_end(ptl_pkg::TT_ARR_BEGIN);
    end else if (b == "]") begin
      s.emit = 1'b1;
      s.res  = mk_end(ptl_pkg::TT_ARR_END);
    end else begin
      s.mode = M_WORD;
      if (b inside {["0":"9"], "+", "-", "."}) begin
        s.wclass = WC_NUMBER;
      end else if (b == "/") begin
        s.wclass = WC_NAME;
      end else begin
        s.wclass = WC_OTHER;
      end
      s.kw   = kw_upd(6'd7, b);
      s.emit = 1'b1;
    end
    return s;
  endfunction

  function automatic sbyte_t string_byte(logic [7:0] b, logic [DW-1:0] d);
    sbyte_t s;
    s.mode  = M_STRING;
    s.depth = d;
    s.emit  = 1'b1;
    s.res   = mk_byte(b);
    if (b == "\\") begin
      s.mode = M_ESCAPE;
      s.emit = 1'b0;
    end else if (b == "(") begin
      if (d >= DEPTH_MAX) begin
        s.mode  = M_IDLE;
        s.depth = '0;
        s.res   = mk_end(ptl_pkg::TT_ERROR);
      end else begin
        s.depth = d + DW'(1);
      end
    end else if (b == ")") begin
      if (d == '0) begin
        s.mode = M_IDLE;
        s.res  = mk_end(ptl_pkg::TT_STRING);
      end else begin
        s.depth = d - DW'(1);
      end
    end
    return s;
  endfunction

  ptl_pkg::lex_state_t s;
  logic [DW-1:0]       d;
  ptl_pkg::res_t       r [2];
  logic [1:0]          n;
  start_t              sv;
  sbyte_t              sb;
  logic [7:0]          oct_v;

  always_comb begin
    s     = st;
    d     = depth;
    n     = 2'd0;
    r[0]  = mk_byte(8'd0);
    r[1]  = mk_byte(8'd0);
    sv    = start_tok(c);
    sb    = string_byte(c, depth);
    oct_v = {st.oct_val[4:0], c[2:0]};

    if (eos) begin
      case (st.mode)
        M_WORD: begin
          r[0] = mk_end(word_type(st.wclass, st.kw));
          n    = 2'd1;
        end
        M_STRING, M_ESCAPE, M_OCTAL, M_LT, M_HEX, M_GT: begin
          r[0] = mk_end(ptl_pkg::TT_ERROR);
          n    = 2'd1;
        end
        default: begin
          n = 2'd0;
        end
      endcase
      s = '0;
      d = '0;
    end else begin
      case (st.mode)
        M_COMMENT: begin
          if (c == 8'h0A || c == 8'h0D) begin
            s.mode = M_IDLE;
          end
        end
        M_WORD: begin
          if (is_space(c) || is_delim(c)) begin
            // The delimiter that ends the word also opens the next token.
            r[0] = mk_end(word_type(st.wclass, st.kw));
            n    = 2'd1;
            s.mode = sv.mode;
            if (sv.mode == M_WORD) begin
              s.wclass = sv.wclass;
              s.kw     = sv.kw;
            end
            if (c == "(") begin
              d = '0;
            end
            if (sv.emit) begin
              r[1] = sv.res;
              n    = 2'd2;
            end
          end else begin
            s.kw = kw_upd(st.kw, c);
            r[0] = mk_byte(c);
            n    = 2'd1;
          end
        end
        M_STRING: begin
          s.mode = sb.mode;
          d      = sb.depth;
          if (sb.emit) begin
            r[0] = sb.res;
            n    = 2'd1;
          end
        end
        M_ESCAPE: begin
          if (c inside {["0":"7"]}) begin
            s.oct_val = {5'd0, c[2:0]};
            s.oct_cnt = 2'd1;
            s.mode    = M_OCTAL;
          end else begin
            s.mode = M_STRING;
            r[0]   = mk_byte(c);
            n      = 2'd1;
          end
        end
        M_OCTAL: begin
          if (c inside {["0":"7"]}) begin
            if (st.oct_cnt >= 2'd2) begin
              r[0]      = mk_byte(oct_v);
              n         = 2'd1;
              s.oct_val = 8'd0;
              s.oct_cnt = 2'd0;
              s.mode    = M_STRING;
            end else begin
              s.oct_val = oct_v;
              s.oct_cnt = st.oct_cnt + 2'd1;
            end
          end else begin
            // A short escape ends: its byte first, then this byte as plain string data.
            r[0]      = mk_byte(st.oct_val);
            n         = 2'd1;
            s.oct_val = 8'd0;
            s.oct_cnt = 2'd0;
            s.mode    = sb.mode;
            d         = sb.depth;
            if (sb.emit) begin
              r[1] = sb.res;
              n    = 2'd2;
            end
          end
        end
        M_LT: begin
          n = 2'd1;
          if (c == "<") begin
            s.mode = M_IDLE;
            r[0]   = mk_end(ptl_pkg::TT_DICT_BEGIN);
          end else if (c == ">") begin
            s.mode = M_IDLE;
            r[0]   = mk_end(ptl_pkg::TT_HEX);
          end else begin
            s.mode = M_HEX;
            r[0]   = mk_byte(c);
          end
        end
        M_HEX: begin
          n = 2'd1;
          if (c == ">") begin
            s.mode = M_IDLE;
            r[0]   = mk_end(ptl_pkg::TT_HEX);
          end else begin
            r[0] = mk_byte(c);
          end
        end
        M_GT: begin
          if (c == ">") begin
            s.mode = M_IDLE;
            r[0]   = mk_end(ptl_pkg::TT_DICT_END);
            n      = 2'd1;
          end else begin
            r[0] = mk_end(ptl_pkg::TT_ERROR);
            n    = 2'd1;
            s.mode = sv.mode;
            if (sv.mode == M_WORD) begin
              s.wclass = sv.wclass;
              s.kw     = sv.kw;
            end
            if (c == "(") begin
              d = '0;
            end
            if (sv.emit) begin
              r[1] = sv.res;
              n    = 2'd2;
            end
          end
        end
        default: begin
          s.mode = sv.mode;
          if (sv.mode == M_WORD) begin
            s.wclass = sv.wclass;
            s.kw     = sv.kw;
          end
          if (c == "(") begin
            d = '0;
          end
          if (sv.emit) begin
            r[0] = sv.res;
            n    = 2'd1;
          end
        end
      endcase
    end

    if (n != 2'd0) begin
      r[~n[0]].last = 1'b1;
    end
  end

  assign st_nxt    = s;
  assign depth_nxt = d;
  assign res0      = r[0];
  assign res1      = r[1];
  assign n_res     = n;

endmodule

>>> tb/sv/lexer_check_pkg.sv
package lexer_check_pkg;
  import ptl_pkg::*;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h00 || c == 8'h09 || c == 8'h0A || c == 8'h0C ||
           c == 8'h0D || c == 8'h20;
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return c == "%" || c == "(" || c == ")" || c == "/" || c == "<" ||
           c == ">" || c == "[" || c == "]" || c == "{" || c == "}";
  endfunction

  // Tracks the lexer state byte by byte and queues the words the block must send.
  class lexer_checker;
    typedef enum int {
      LX_IDLE, LX_COMMENT, LX_WORD, LX_STRING, LX_ESCAPE, LX_OCTAL, LX_LT, LX_HEX, LX_GT
    } lex_mode_e;
    typedef enum int {WC_NUMBER, WC_NAME, WC_OTHER} word_class_e;

    lex_mode_e   mode;
    int unsigned depth;
    logic [8:0]  oct_val;
    int          oct_cnt;
    word_class_e wclass;
    int          kw_cnt;
    logic [2:0]  kw_alive;
    string       kw_names[3];

    res_t expected_events[$];
    res_t step_events[$];
    int   mismatches;
    int   words_checked;
    int   bytes_taken;
    int   ends_seen[16];

    function new();
      kw_names[0] = "null";
      kw_names[1] = "true";
      kw_names[2] = "false";
      mismatches = 0;
      words_checked = 0;
      bytes_taken = 0;
      foreach (ends_seen[i]) ends_seen[i] = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode = LX_IDLE;
      depth = 0;
      oct_val = '0;
      oct_cnt = 0;
      wclass = WC_NUMBER;
      kw_cnt = 0;
      kw_alive = '0;
    endfunction

    function void add_event(logic kind, logic [7:0] data, logic [3:0] ttype);
      res_t r;
      r.kind = kind;
      r.data = data;
      r.ttype = ttype;
      r.last = 1'b0;
      step_events = {step_events, r};
    endfunction

    function void update_keyword(logic [7:0] c);
      for (int k = 0; k < 3; k++) begin
        if (kw_alive[k] && (kw_cnt >= kw_names[k].len() || kw_names[k][kw_cnt] != c)) begin
          kw_alive[k] = 1'b0;
        end
      end
      if (kw_cnt < 7) kw_cnt++;
    endfunction

    function logic [3:0] word_token_type();
      if (wclass == WC_NUMBER) return TT_NUMBER;
      if (wclass == WC_NAME) return TT_NAME;
      if (kw_alive[0] && kw_cnt == 4) return TT_NULL;
      if (kw_alive[1] && kw_cnt == 4) return TT_TRUE;
      if (kw_alive[2] && kw_cnt == 5) return TT_FALSE;
      return TT_OPERATOR;
    endfunction

    function void begin_token(logic [7:0] c);
      mode = LX_IDLE;
      if (is_space(c)) return;
      case (c)
        "%": mode = LX_COMMENT;
        "(": begin
          mode = LX_STRING;
          depth = 0;
        end
        "<": mode = LX_LT;
        ">": mode = LX_GT;
        "[": add_event(EV_END, 8'h00, TT_ARR_BEGIN);
        "]": add_event(EV_END, 8'h00, TT_ARR_END);
        default: begin
          // Anything else opens a word, including a stray ')', '{' or '}'.
          mode = LX_WORD;
          if ((c >= "0" && c <= "9") || c == "+" || c == "-" || c == ".") wclass = WC_NUMBER;
          else if (c == "/") wclass = WC_NAME;
          else wclass = WC_OTHER;
          kw_cnt = 0;
          kw_alive = 3'b111;
          update_keyword(c);
          add_event(EV_BYTE, c, TT_ERROR);
        end
      endcase
    endfunction

    function void string_char(logic [7:0] c);
      mode = LX_STRING;
      if (c == "\\") begin
        mode = LX_ESCAPE;
      end else if (c == "(") begin
        if (depth >= MAX_NEST_DEF) begin
          mode = LX_IDLE;
          depth = 0;
          add_event(EV_END, 8'h00, TT_ERROR);
        end else begin
          depth++;
          add_event(EV_BYTE, c, TT_ERROR);
        end
      end else if (c == ")") begin
        if (depth == 0) begin
          mode = LX_IDLE;
          add_event(EV_END, 8'h00, TT_STRING);
        end else begin
          depth--;
          add_event(EV_BYTE, c, TT_ERROR);
        end
      end else begin
        add_event(EV_BYTE, c, TT_ERROR);
      end
    endfunction

    function void absorb_byte(logic [7:0] c, bit eos);
      bit is_oct;
      is_oct = (c >= "0" && c <= "7");
      step_events.delete();
      bytes_taken++;
      if (eos) begin
        case (mode)
          LX_WORD: add_event(EV_END, 8'h00, word_token_type());
          LX_STRING, LX_ESCAPE, LX_OCTAL, LX_LT, LX_HEX, LX_GT:
            add_event(EV_END, 8'h00, TT_ERROR);
          default: ;
        endcase
        clear_state();
      end else begin
        case (mode)
          LX_COMMENT: begin
            if (c == 8'h0A || c == 8'h0D) mode = LX_IDLE;
          end
          LX_WORD: begin
            if (is_space(c) || is_delim(c)) begin
              add_event(EV_END, 8'h00, word_token_type());
              begin_token(c);
            end else begin
              update_keyword(c);
              add_event(EV_BYTE, c, TT_ERROR);
            end
          end
          LX_STRING: string_char(c);
          LX_ESCAPE: begin
            if (is_oct) begin
              oct_val = {6'b0, c[2:0]};
              oct_cnt = 1;
              mode = LX_OCTAL;
            end else begin
              mode = LX_STRING;
              add_event(EV_BYTE, c, TT_ERROR);
            end
          end
          LX_OCTAL: begin
            if (is_oct) begin
              oct_val = {oct_val[5:0], c[2:0]};
              oct_cnt++;
              if (oct_cnt >= 3) begin
                add_event(EV_BYTE, oct_val[7:0], TT_ERROR);
                oct_val = '0;
                oct_cnt = 0;
                mode = LX_STRING;
              end
            end else begin
              // A short escape is flushed first, then the byte counts as string text.
              add_event(EV_BYTE, oct_val[7:0], TT_ERROR);
              oct_val = '0;
              oct_cnt = 0;
              string_char(c);
            end
          end
          LX_LT: begin
            if (c == "<") begin
              mode = LX_IDLE;
              add_event(EV_END, 8'h00, TT_DICT_BEGIN);
            end else if (c == ">") begin
              mode = LX_IDLE;
              add_event(EV_END, 8'h00, TT_HEX);
            end else begin
              mode = LX_HEX;
              add_event(EV_BYTE, c, TT_ERROR);
            end
          end
          LX_HEX: begin
            if (c == ">") begin
              mode = LX_IDLE;
              add_event(EV_END, 8'h00, TT_HEX);
            end else begin
              add_event(EV_BYTE, c, TT_ERROR);
            end
          end
          LX_GT: begin
            if (c == ">") begin
              mode = LX_IDLE;
              add_event(EV_END, 8'h00, TT_DICT_END);
            end else begin
              add_event(EV_END, 8'h00, TT_ERROR);
              begin_token(c);
            end
          end
          default: begin_token(c);
        endcase
      end
      if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
      expected_events = {expected_events, step_events};
    endfunction

    function void match_event(logic kind, logic [7:0] data, logic [3:0] ttype, logic last);
      res_t  exp_word;
      string exp_txt;
      string got_txt;
      words_checked++;
      if (kind === EV_END && !$isunknown(ttype)) ends_seen[ttype]++;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 40) begin
          $display("%0t: word with none expected: kind=%0d byte=%02h type=%0d last=%0d",
                   $time, kind, data, ttype, last);
        end
        return;
      end
      exp_word = expected_events.pop_front();
      if (kind !== exp_word.kind || data !== exp_word.data ||
          ttype !== exp_word.ttype || last !== exp_word.last) begin
        mismatches++;
        if (mismatches <= 40) begin
          exp_txt = $sformatf("kind=%0d byte=%02h type=%0d last=%0d",
                              exp_word.kind, exp_word.data, exp_word.ttype, exp_word.last);
          got_txt = $sformatf("kind=%0d byte=%02h type=%0d last=%0d",
                              kind, data, ttype, last);
          $display("%0t: mismatch expected %s, got %s", $time, exp_txt, got_txt);
        end
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

endpackage

>>> tb/sv/testbench.sv
module testbench;
  import ptl_pkg::*;
  import lexer_check_pkg::*;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_CHOPPY} rx_style_e;

  localparam int STREAM_BYTES = 1850;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ptl_in_if  in_ch();
  ptl_out_if out_ch();

  pdf_token_lexer_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lexer_checker token_pred;
  int burst_left;
  int bytes_sent;
  bit hold_request;

  // Receiver: ready follows a changing style, with one long hold on request.
  initial begin
    int        hold_left;
    int        style_left;
    int        stall_left;
    rx_style_e style;
    logic      rdy;
    hold_left = 0;
    style_left = 0;
    stall_left = 0;
    style = RX_OPEN;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else begin
        if (style_left == 0) begin
          style = rx_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(20, 150);
        end
        style_left--;
        case (style)
          RX_OPEN:   rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          RX_MOSTLY: rdy = ($urandom_range(0, 9) != 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              rdy = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
              stall_left = $urandom_range(1, 8) - 1;
              rdy = 1'b0;
            end else begin
              rdy = 1'b1;
            end
          end
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      token_pred.match_event(out_ch.event_kind, out_ch.content_byte, out_ch.token_type,
                             out_ch.run_last);
    end
  end

  initial begin
    #5000000;
    $display("testbench: errors");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [7:0] b, input bit eos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    token_pred.absorb_byte(b, eos);
    bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_eos();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0C;
      4: return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] pick_regular();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (is_delim(c));
    return c;
  endfunction

  task automatic gen_word();
    string      kws[3];
    string      num_start;
    logic [7:0] c;
    int         n;
    kws[0] = "null";
    kws[1] = "true";
    kws[2] = "false";
    num_start = "+-.0123456789";
    case ($urandom_range(0, 3))
      0: begin
        send_word(num_start[$urandom_range(0, 12)], 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) begin
          c = ($urandom_range(0, 5) == 0) ? "." : 8'("0" + $urandom_range(0, 9));
          send_word(c, 1'b0);
        end
      end
      1: begin
        send_word("/", 1'b0);
        n = $urandom_range(0, 6);
        repeat (n) send_word(pick_regular(), 1'b0);
      end
      2: begin
        n = $urandom_range(0, 2);
        case ($urandom_range(0, 3))
          1: send_text(kws[n].substr(0, kws[n].len() - 2));
          2: begin
            send_text(kws[n]);
            send_word(pick_regular(), 1'b0);
          end
          default: send_text(kws[n]);
        endcase
      end
      default: begin
        case ($urandom_range(0, 4))
          0: send_word(")", 1'b0);
          1: send_word("{", 1'b0);
          2: send_word("}", 1'b0);
          default: send_word(pick_regular(), 1'b0);
        endcase
        n = $urandom_range(0, 5);
        repeat (n) send_word(pick_regular(), 1'b0);
      end
    endcase
    if ($urandom_range(0, 9) == 0) send_eos();
    else if ($urandom_range(0, 4) != 0) send_word(pick_space(), 1'b0);
  endtask

  task automatic gen_string();
    int         opened;
    int         pieces;
    int         digits;
    logic [7:0] c;
    opened = 0;
    send_word("(", 1'b0);
    pieces = $urandom_range(0, 12);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        5: begin
          send_word("\\", 1'b0);
          digits = $urandom_range(1, 3);
          repeat (digits) send_word(8'("0" + $urandom_range(0, 7)), 1'b0);
          // Follow a short escape with a byte that may or may not be an octal digit.
          if (digits < 3 && $urandom_range(0, 1)) send_word(8'("0" + $urandom_range(6, 9)), 1'b0);
        end
        6: begin
          send_word("\\", 1'b0);
          send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        7: begin
          if (opened < 6) begin
            opened++;
            send_word("(", 1'b0);
          end
        end
        8: begin
          if (opened > 0) begin
            opened--;
            send_word(")", 1'b0);
          end
        end
        default: begin
          do c = 8'($urandom_range(0, 255)); while (c == "\\" || c == "(" || c == ")");
          send_word(c, 1'b0);
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      send_eos();
    end else begin
      repeat (opened) send_word(")", 1'b0);
      send_word(")", 1'b0);
    end
  endtask

  task automatic gen_hex();
    int         n;
    logic [7:0] c;
    send_word("<", 1'b0);
    n = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == ">" || (i == 0 && c == "<"));
      send_word(c, 1'b0);
    end
    if ($urandom_range(0, 9) == 0) send_eos();
    else send_word(">", 1'b0);
  endtask

  task automatic gen_comment();
    int         n;
    logic [7:0] c;
    send_word("%", 1'b0);
    n = $urandom_range(0, 10);
    repeat (n) begin
      do c = 8'($urandom_range(0, 255)); while (c == 8'h0A || c == 8'h0D);
      send_word(c, 1'b0);
    end
    if ($urandom_range(0, 9) == 0) send_eos();
    else send_word($urandom_range(0, 1) ? 8'h0A : 8'h0D, 1'b0);
  endtask

  task automatic gen_token();
    logic [7:0] c;
    int         n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 19: gen_word();
      5, 6, 7: gen_string();
      8, 9: gen_hex();
      10, 11: begin
        case ($urandom_range(0, 3))
          0: send_text("[");
          1: send_text("]");
          2: send_text("<<");
          default: send_text(">>");
        endcase
      end
      12: begin
        send_word(">", 1'b0);
        if ($urandom_range(0, 7) == 0) begin
          send_eos();
        end else begin
          do c = 8'($urandom_range(0, 255)); while (c == ">");
          send_word(c, 1'b0);
        end
      end
      13: gen_comment();
      14, 15: begin
        n = $urandom_range(1, 3);
        repeat (n) send_word(pick_space(), 1'b0);
      end
      16, 17: begin
        n = $urandom_range(1, 4);
        repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
      end
      default: send_eos();
    endcase
  endtask

  // One string at the deepest legal nesting, then one that nests a level too far.
  // The stream is closed first so that both strings start from idle.
  task automatic gen_deep_nesting();
    send_eos();
    send_word("(", 1'b0);
    repeat (MAX_NEST_DEF) send_word("(", 1'b0);
    repeat (MAX_NEST_DEF) send_word(")", 1'b0);
    send_word(")", 1'b0);
    repeat (MAX_NEST_DEF + 2) send_word("(", 1'b0);
    send_word(" ", 1'b0);
  endtask

  initial begin
    bit hold_done;
    bit drain_done;
    bit nest_done;
    int kinds;
    token_pred = new();
    burst_left = 0;
    bytes_sent = 0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    nest_done = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.end_of_stream = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Delimiters, a hex string holding a tab, escapes, a keyword cut by a lone '>'.
    send_text("[<<>><\t>");
    send_text("(\\101\\7x\\\\)");
    send_text("true>x");
    send_eos();

    while (bytes_sent < STREAM_BYTES) begin
      if (!hold_done && bytes_sent > 500) begin
        hold_done = 1'b1;
        hold_request = 1'b1;
        burst_left = HOLD_CYCLES;
      end
      if (!nest_done && bytes_sent > 800) begin
        nest_done = 1'b1;
        gen_deep_nesting();
      end
      if (!drain_done && bytes_sent > 1400) begin
        drain_done = 1'b1;
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (token_pred.pending() != 0);
      end
      gen_token();
    end
    send_eos();

    in_ch.valid <= 1'b0;
    do @(negedge clk); while (token_pred.pending() != 0);
    repeat (20) @(negedge clk);

    kinds = 0;
    foreach (token_pred.ends_seen[i]) if (token_pred.ends_seen[i] > 0) kinds++;
    $display("Run fed %0d stream bytes and checked %0d result words; %0d token types ended.",
             token_pred.bytes_taken, token_pred.words_checked, kinds);
    $display("Deep nesting, nesting overflow, a long output hold and a full drain were included.");
    if (token_pred.mismatches == 0 && token_pred.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> pdf_token_lexer_top.f
design/ptl_pkg.sv
design/ptl_if.sv
design/ptl_step.sv
design/pdf_token_lexer_top.sv
tb/sv/lexer_check_pkg.sv
tb/sv/testbench.sv
